[rtl/assert_macros.svh]
// Assertion macros used by the dispatcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define PAD_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define PAD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

[rtl/pad_pkg.sv]
// Package: constants, types and helpers of the priority admission dispatcher.
`timescale 1ns / 1ps

package pad_pkg;

    localparam int ENTRIES   = 32;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int TAG_W     = 8;
    localparam int PRI_W     = 4;
    localparam int RAM_W     = 16;
    localparam int LEVELS    = 1 << PRI_W;
    localparam int CFG_W     = 16;

    localparam logic [RAM_W-1:0] CPU1_BUDGET_RST = RAM_W'(512);
    localparam logic [RAM_W-1:0] CPU2_BUDGET_RST = RAM_W'(1536);

    typedef enum logic {
        CMD_LOAD     = 1'b0,
        CMD_SCHEDULE = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_CPU1_BUDGET = 1'b0,
        CFG_CPU2_BUDGET = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        CPU_FIRST  = 1'b0,
        CPU_SECOND = 1'b1
    } cpu_t;

    typedef enum logic [1:0] {
        QSEL_NONE   = 2'd0,
        QSEL_HIGH   = 2'd1,
        QSEL_MEDIUM = 2'd2,
        QSEL_LOW    = 2'd3
    } qsel_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] pri;
        logic [RAM_W-1:0] ram;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [PRI_W-1:0] lvl;
    } lvl_find_t;

    // Lowest set bit of a priority presence mask.
    function automatic lvl_find_t first_level(input logic [LEVELS-1:0] mask);
        lvl_find_t res;
        res.found = 1'b0;
        res.lvl   = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                res.found = 1'b1;
                res.lvl   = PRI_W'(i);
            end
        end
        return res;
    endfunction

endpackage

[rtl/priority_admission_dispatcher.sv]
// Top level: job table, priority-ordered admission walk and result stage.
`timescale 1ns / 1ps

// A load (cmd = load) never raises busy: a new command
// may follow in the very next cycle. A load into a full table is dropped.
// A schedule command with loaded jobs raises busy from the next cycle and walks the job table
// once per distinct priority level present among the loaded jobs, reading one
// entry per cycle through the single read port of the table memory; jobs of
// the current level are reported in load order, which gives the stable sort.
// Each result passes the scan address, the table read register and the result
// registers in that order, and is strobed by result_valid for exactly one
// cycle. The receiver cannot stall results: they are gone after that cycle.
// last marks the final result of a run; an empty schedule only reloads the
// budgets and gives no result.
// Configuration writes take effect at once and belong in idle periods.
module priority_admission_dispatcher
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [pad_pkg::CFG_W-1:0]   cfg_wdata,

    input  logic                        start,
    output logic                        busy,
    input  logic                        cmd,
    input  logic [pad_pkg::TAG_W-1:0]   job_tag,
    input  logic [pad_pkg::PRI_W-1:0]   job_priority,
    input  logic [pad_pkg::RAM_W-1:0]   ram_need,

    output logic                        result_valid,
    output logic [pad_pkg::TAG_W-1:0]   out_tag,
    output logic [pad_pkg::PRI_W-1:0]   out_priority,
    output logic                        cpu_select,
    output logic                        admitted,
    output logic [1:0]                  queue_select,
    output logic                        queue_full,
    output logic                        last
);

    import pad_pkg::*;

`include "assert_macros.svh"

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // Configuration
    logic [RAM_W-1:0]   cpu1_budget_reg;
    logic [RAM_W-1:0]   cpu2_budget_reg;

    // Job table memory, undefined until loaded
    entry_t             table_mem [ENTRIES];
    entry_t             rd_q_reg;

    // Load side
    logic [CNT_W-1:0]   entry_count_reg;
    logic [LEVELS-1:0]  pri_mask_reg;

    // Scan sequencer
    state_t             state_reg;
    logic [CNT_W-1:0]   sched_n_reg;
    logic [LEVELS-1:0]  sched_mask_reg;
    logic [PRI_W-1:0]   scan_lvl_reg;
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic               rd_valid_reg;
    logic [PRI_W-1:0]   rd_lvl_reg;
    logic [CNT_W-1:0]   emit_cnt_reg;

    // Budgets and persistent queue fills
    logic [RAM_W-1:0]   rem_first_reg;
    logic [RAM_W-1:0]   rem_second_reg;
    logic [CNT_W-1:0]   queue_fill_reg [3];

    // Result registers
    logic               result_valid_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [PRI_W-1:0]   out_priority_reg;
    logic               cpu_select_reg;
    logic               admitted_reg;
    logic [1:0]         queue_select_reg;
    logic               queue_full_reg;
    logic               last_reg;

    // Combinational
    logic               accept;
    logic               do_load;
    logic               do_sched;
    lvl_find_t          first_lvl;
    lvl_find_t          next_lvl;
    logic [LEVELS-1:0]  mask_above;
    logic               scan_at_end;
    logic               rd_hit;
    logic               hit_cpu;
    logic [RAM_W-1:0]   hit_budget;
    logic               hit_adm;
    logic               hit_queued;
    logic [1:0]         hit_qidx;
    logic               hit_qfull;
    logic [RAM_W-1:0]   rem_first_next;
    logic [RAM_W-1:0]   rem_second_next;

    assign busy     = (state_reg != S_IDLE) || rd_valid_reg;
    assign accept   = start && !busy;
    assign do_load  = accept && (cmd == CMD_LOAD) && (entry_count_reg < CNT_W'(ENTRIES));
    assign do_sched = accept && (cmd == CMD_SCHEDULE);

    // Level search: first level at schedule start, next level after a pass
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            mask_above[i] = sched_mask_reg[i] && (5'(i) > {1'b0, scan_lvl_reg});
        end
        first_lvl   = first_level(pri_mask_reg);
        next_lvl    = first_level(mask_above);
        scan_at_end = ({1'b0, scan_addr_reg} + CNT_W'(1)) == sched_n_reg;
    end

    // Admission of the entry read in the previous cycle
    always_comb
    begin
        rd_hit     = rd_valid_reg && (rd_q_reg.pri == rd_lvl_reg);
        hit_cpu    = (rd_q_reg.pri != '0) ? CPU_SECOND : CPU_FIRST;
        hit_budget = (hit_cpu == CPU_SECOND) ? rem_second_reg : rem_first_reg;
        hit_adm    = hit_budget >= rd_q_reg.ram;
        // priorities 1..3 map straight onto the high, medium, low queue codes
        hit_queued = hit_adm && (rd_q_reg.pri >= PRI_W'(1)) && (rd_q_reg.pri <= PRI_W'(3));
        hit_qidx   = rd_q_reg.pri[1:0] - 2'd1;
        hit_qfull  = hit_queued && (queue_fill_reg[hit_qidx] >= CNT_W'(ENTRIES));

        rem_first_next  = rem_first_reg;
        rem_second_next = rem_second_reg;
        if (do_sched)
        begin
            rem_first_next  = cpu1_budget_reg;
            rem_second_next = cpu2_budget_reg;
        end
        else if (rd_hit && hit_adm)
        begin
            if (hit_cpu == CPU_SECOND)
                rem_second_next = rem_second_reg - rd_q_reg.ram;
            else
                rem_first_next = rem_first_reg - rd_q_reg.ram;
        end
    end

    // Table memory: one write port for loads, one registered read port for the walk
    always_ff @(posedge clk)
    begin
        if (do_load)
            table_mem[entry_count_reg[ADDR_W-1:0]] <= '{tag: job_tag, pri: job_priority,
                                                        ram: ram_need};
        rd_q_reg <= table_mem[scan_addr_reg];
    end

    // Control, budgets, queues and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu1_budget_reg   <= CPU1_BUDGET_RST;
            cpu2_budget_reg   <= CPU2_BUDGET_RST;
            entry_count_reg   <= '0;
            pri_mask_reg      <= '0;
            state_reg         <= S_IDLE;
            sched_n_reg       <= '0;
            sched_mask_reg    <= '0;
            scan_lvl_reg      <= '0;
            scan_addr_reg     <= '0;
            rd_valid_reg      <= 1'b0;
            rd_lvl_reg        <= '0;
            emit_cnt_reg      <= '0;
            rem_first_reg     <= '0;
            rem_second_reg    <= '0;
            queue_fill_reg[0] <= '0;
            queue_fill_reg[1] <= '0;
            queue_fill_reg[2] <= '0;
            result_valid_reg  <= 1'b0;
            out_tag_reg       <= '0;
            out_priority_reg  <= '0;
            cpu_select_reg    <= 1'b0;
            admitted_reg      <= 1'b0;
            queue_select_reg  <= QSEL_NONE;
            queue_full_reg    <= 1'b0;
            last_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CPU1_BUDGET: cpu1_budget_reg <= cfg_wdata;
                    CFG_CPU2_BUDGET: cpu2_budget_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (do_load)
            begin
                entry_count_reg            <= entry_count_reg + CNT_W'(1);
                pri_mask_reg[job_priority] <= 1'b1;
            end

            rem_first_reg  <= rem_first_next;
            rem_second_reg <= rem_second_next;

            // walk sequencer
            rd_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (do_sched)
                    begin
                        // hand the table to the walk and empty it for new loads
                        sched_n_reg     <= entry_count_reg;
                        sched_mask_reg  <= pri_mask_reg;
                        entry_count_reg <= '0;
                        pri_mask_reg    <= '0;
                        emit_cnt_reg    <= '0;
                        scan_lvl_reg    <= first_lvl.lvl;
                        scan_addr_reg   <= '0;
                        if (first_lvl.found)
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    rd_valid_reg <= 1'b1;
                    rd_lvl_reg   <= scan_lvl_reg;
                    if (scan_at_end)
                    begin
                        scan_addr_reg <= '0;
                        scan_lvl_reg  <= next_lvl.lvl;
                        if (!next_lvl.found)
                            state_reg <= S_IDLE;
                    end
                    else
                    begin
                        scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // result stage
            result_valid_reg <= rd_hit;
            if (rd_hit)
            begin
                emit_cnt_reg     <= emit_cnt_reg + CNT_W'(1);
                out_tag_reg      <= rd_q_reg.tag;
                out_priority_reg <= rd_q_reg.pri;
                cpu_select_reg   <= hit_cpu;
                admitted_reg     <= hit_adm;
                queue_select_reg <= hit_queued ? rd_q_reg.pri[1:0] : QSEL_NONE;
                queue_full_reg   <= hit_qfull;
                last_reg         <= (emit_cnt_reg + CNT_W'(1)) == sched_n_reg;
                if (hit_queued && !hit_qfull)
                    queue_fill_reg[hit_qidx] <= queue_fill_reg[hit_qidx] + CNT_W'(1);
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_priority_reg;
    assign cpu_select   = cpu_select_reg;
    assign admitted     = admitted_reg;
    assign queue_select = queue_select_reg;
    assign queue_full   = queue_full_reg;
    assign last         = last_reg;

    // a matching read always turns into a strobed result
    `PAD_ASSERT_NEXT(a_hit_gives_result, clk, rst_n, rd_hit, result_valid)
    // the final result of a run is not followed by another in the next cycle
    `PAD_ASSERT_NEXT(a_last_then_quiet, clk, rst_n, result_valid && last, !result_valid)
    // a full-queue drop only happens to an admitted, queued job
    `PAD_ASSERT_IMPL(a_full_needs_queue, clk, rst_n, result_valid && queue_full,
                     admitted && (queue_select != QSEL_NONE))
    // never more results than jobs handed to the walk
    `PAD_ASSERT_IMPL(a_emit_bounded, clk, rst_n, state_reg == S_SCAN,
                     emit_cnt_reg <= sched_n_reg)

endmodule
